FILE: rtl/otf_pkg.sv
// shared constants, beat types and controller/datapath command structs for the otsu finder
package otf_pkg;

  localparam int BIN_COUNT         = 256;
  localparam int PIX_W             = 8;
  localparam int MAX_REGION_PIXELS = 65536;

  localparam int BIN_W    = $clog2(BIN_COUNT);
  localparam int CNT_W    = $clog2(MAX_REGION_PIXELS + 1);
  localparam int SUM_W    = CNT_W + PIX_W;
  localparam int DIFF_W   = CNT_W + SUM_W;
  localparam int DEN_W    = 2 * CNT_W;
  localparam int SQ_W     = 2 * DIFF_W;

  // iterative multiplier: full-width a operand, b consumed one digit per cycle
  localparam int DIGIT_W   = 8;
  localparam int MUL_B_RAW = (DIFF_W > DEN_W) ? DIFF_W : DEN_W;
  localparam int MUL_STEPS = (MUL_B_RAW + DIGIT_W - 1) / DIGIT_W;
  localparam int MUL_A_W   = SQ_W;
  localparam int MUL_B_W   = MUL_STEPS * DIGIT_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int STEP_W    = $clog2(MUL_STEPS + 1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } pix_t;

  typedef struct packed {
    logic [BIN_W-1:0] threshold;
    logic             split_found;
  } res_t;

  typedef enum logic [1:0] {
    MSEL_SQ = 2'd0,
    MSEL_P1 = 2'd1,
    MSEL_P2 = 2'd2
  } msel_t;

  typedef struct packed {
    logic  pix_acc;
    logic  clear_wr;
    logic  bin_clr;
    logic  bin_inc;
    logic  sweep_acc;
    logic  calc_prod;
    logic  calc_diff;
    logic  mul_start;
    msel_t mul_sel;
    logic  cap_sq;
    logic  cap_p1;
    logic  cap_p2;
    logic  best_upd;
    logic  region_clr;
    logic  res_load;
  } cmd_t;

  typedef struct packed {
    logic bin_last;
    logic skip;
    logic mul_done;
    logic better;
  } stat_t;

endpackage

FILE: rtl/otf_ram.sv
// generic simple dual-port ram with registered read
module otf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/otf_mul.sv
// iterative multiplier, one digit of b per cycle, msb digit first
module otf_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [otf_pkg::MUL_A_W-1:0]  a,
  input  logic [otf_pkg::MUL_B_W-1:0]  b,
  output logic                         done,
  output logic [otf_pkg::PROD_W-1:0]   prod
);

  logic                                            busy;
  logic [otf_pkg::STEP_W-1:0]                      cnt;
  logic [otf_pkg::MUL_A_W-1:0]                     a_reg;
  logic [otf_pkg::MUL_B_W-1:0]                     b_reg;
  logic [otf_pkg::MUL_A_W+otf_pkg::DIGIT_W-1:0]    part;

  assign part = a_reg * b_reg[otf_pkg::MUL_B_W-1 -: otf_pkg::DIGIT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= otf_pkg::STEP_W'(otf_pkg::MUL_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == otf_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_reg <= b;
      prod  <= '0;
    end else if (busy) begin
      prod  <= (prod << otf_pkg::DIGIT_W) + otf_pkg::PROD_W'(part);
      b_reg <= b_reg << otf_pkg::DIGIT_W;
    end
  end

endmodule

FILE: rtl/otf_datapath.sv
// histogram memory, totals, sweep accumulators and variance compare datapath
module otf_datapath (
  input  logic            clk,
  input  logic            rst,
  input  otf_pkg::pix_t   pix,
  input  otf_pkg::cmd_t   cmd,
  output otf_pkg::stat_t  stat,
  output otf_pkg::res_t   res
);

  localparam int CW = otf_pkg::CNT_W;
  localparam int BW = otf_pkg::BIN_W;

  logic [BW-1:0]                 idx;
  logic [CW-1:0]                 pixel_total;
  logic [otf_pkg::SUM_W-1:0]     weighted_total;
  logic                          acc_vld;
  logic [BW-1:0]                 acc_addr;
  logic                          fwd_vld;
  logic [BW-1:0]                 fwd_addr;
  logic [CW-1:0]                 fwd_val;
  logic [CW-1:0]                 old_val;
  logic [CW-1:0]                 inc_val;
  logic                          take;

  logic                          ram_we;
  logic [BW-1:0]                 ram_waddr;
  logic [CW-1:0]                 ram_wdata;
  logic [BW-1:0]                 ram_raddr;
  logic [CW-1:0]                 ram_rdata;

  logic [CW-1:0]                 w1;
  logic [otf_pkg::SUM_W-1:0]     s1;
  logic [otf_pkg::DIFF_W-1:0]    prod_a;
  logic [otf_pkg::DIFF_W-1:0]    prod_b;
  logic [otf_pkg::DEN_W-1:0]     den;
  logic [otf_pkg::DIFF_W-1:0]    diff;
  logic [otf_pkg::SQ_W-1:0]      sq;
  logic [otf_pkg::PROD_W-1:0]    p1;
  logic [otf_pkg::PROD_W-1:0]    p2;

  logic [otf_pkg::DIFF_W-1:0]    best_d;
  logic [otf_pkg::DEN_W-1:0]     best_den;
  logic [otf_pkg::SQ_W-1:0]      best_sq;
  logic [BW-1:0]                 best_bin;

  logic [otf_pkg::MUL_A_W-1:0]   mul_a;
  logic [otf_pkg::MUL_B_W-1:0]   mul_b;
  logic                          mul_done;
  logic [otf_pkg::PROD_W-1:0]    mul_prod;
  logic                          found;

  // pixels beyond the count limit are dropped
  assign take = cmd.pix_acc && (pixel_total < CW'(otf_pkg::MAX_REGION_PIXELS));

  // back-to-back hits on one bin see the value still in flight
  assign old_val = (fwd_vld && (fwd_addr == acc_addr)) ? fwd_val : ram_rdata;
  assign inc_val = old_val + 1'b1;

  assign ram_we    = acc_vld || cmd.clear_wr || cmd.sweep_acc;
  assign ram_waddr = acc_vld ? acc_addr : idx;
  assign ram_wdata = acc_vld ? inc_val : '0;
  assign ram_raddr = cmd.pix_acc ? pix.pixel : idx;

  otf_ram #(
    .WIDTH (CW),
    .DEPTH (otf_pkg::BIN_COUNT)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.bin_clr) begin
      idx <= '0;
    end else if (cmd.bin_inc) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.region_clr) begin
      pixel_total    <= '0;
      weighted_total <= '0;
      acc_vld        <= 1'b0;
      fwd_vld        <= 1'b0;
    end else begin
      acc_vld <= take;
      if (take) begin
        pixel_total    <= pixel_total + 1'b1;
        weighted_total <= weighted_total + otf_pkg::SUM_W'(pix.pixel);
      end
      if (acc_vld) begin
        fwd_vld <= 1'b1;
      end else if (cmd.sweep_acc) begin
        fwd_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_addr <= pix.pixel;
    if (acc_vld) begin
      fwd_addr <= acc_addr;
      fwd_val  <= inc_val;
    end
  end

  // class-1 count and sum over the sweep
  always_ff @(posedge clk) begin
    if (rst || cmd.bin_clr) begin
      w1 <= '0;
      s1 <= '0;
    end else if (cmd.sweep_acc) begin
      w1 <= w1 + ram_rdata;
      s1 <= s1 + otf_pkg::SUM_W'(ram_rdata) * otf_pkg::SUM_W'(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_prod) begin
      prod_a <= otf_pkg::DIFF_W'(pixel_total) * otf_pkg::DIFF_W'(s1);
      prod_b <= otf_pkg::DIFF_W'(w1) * otf_pkg::DIFF_W'(weighted_total);
      den    <= otf_pkg::DEN_W'(w1) * otf_pkg::DEN_W'(pixel_total - w1);
    end
    if (cmd.calc_diff) begin
      diff <= (prod_a > prod_b) ? (prod_a - prod_b) : (prod_b - prod_a);
    end
    if (cmd.cap_sq) begin
      sq <= otf_pkg::SQ_W'(mul_prod);
    end
    if (cmd.cap_p1) begin
      p1 <= mul_prod;
    end
    if (cmd.cap_p2) begin
      p2 <= mul_prod;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      otf_pkg::MSEL_SQ: begin
        mul_a = otf_pkg::MUL_A_W'(diff);
        mul_b = otf_pkg::MUL_B_W'(diff);
      end
      otf_pkg::MSEL_P1: begin
        mul_a = otf_pkg::MUL_A_W'(sq);
        mul_b = otf_pkg::MUL_B_W'(best_den);
      end
      otf_pkg::MSEL_P2: begin
        mul_a = otf_pkg::MUL_A_W'(best_sq);
        mul_b = otf_pkg::MUL_B_W'(den);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  otf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.region_clr) begin
      best_d   <= '0;
      best_den <= otf_pkg::DEN_W'(1);
      best_sq  <= '0;
      best_bin <= '0;
    end else if (cmd.best_upd) begin
      best_d   <= diff;
      best_den <= den;
      best_sq  <= sq;
      best_bin <= idx;
    end
  end

  assign found = (best_d != '0);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res.threshold   <= found ? best_bin : '0;
      res.split_found <= found;
    end
  end

  assign stat.bin_last = (idx == BW'(otf_pkg::BIN_COUNT - 1));
  assign stat.skip     = (w1 == '0) || (w1 >= pixel_total);
  assign stat.mul_done = mul_done;
  assign stat.better   = (p1 > p2);

endmodule

FILE: rtl/otf_ctrl.sv
// sequencer for clear pass, pixel intake, bin sweep and result hand-off
module otf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            pix_valid,
  input  otf_pkg::pix_t   pix,
  output logic            pix_stall,
  output logic            res_valid,
  input  logic            res_stall,
  input  otf_pkg::stat_t  stat,
  output otf_pkg::cmd_t   cmd
);

  typedef enum logic [16:0] {
    ST_CLEAR   = 17'h00001,
    ST_ACCUM   = 17'h00002,
    ST_FLUSH   = 17'h00004,
    ST_READ    = 17'h00008,
    ST_ADD     = 17'h00010,
    ST_CHECK   = 17'h00020,
    ST_PROD    = 17'h00040,
    ST_DIFF    = 17'h00080,
    ST_SQ_GO   = 17'h00100,
    ST_SQ_WAIT = 17'h00200,
    ST_P1_GO   = 17'h00400,
    ST_P1_WAIT = 17'h00800,
    ST_P2_GO   = 17'h01000,
    ST_P2_WAIT = 17'h02000,
    ST_CMP     = 17'h04000,
    ST_NEXT    = 17'h08000,
    ST_DONE    = 17'h10000
  } state_t;

  state_t state;
  state_t state_next;

  assign pix_stall = (state != ST_ACCUM);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = otf_pkg::MSEL_SQ;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.bin_inc  = 1'b1;
        if (stat.bin_last) begin
          cmd.bin_clr = 1'b1;
          state_next  = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.pix_acc = pix_valid;
        if (pix_valid && pix.last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.bin_clr = 1'b1;
        state_next  = ST_READ;
      end
      ST_READ: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.sweep_acc = 1'b1;
        state_next    = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = stat.skip ? ST_NEXT : ST_PROD;
      end
      ST_PROD: begin
        cmd.calc_prod = 1'b1;
        state_next    = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_next    = ST_SQ_GO;
      end
      ST_SQ_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = otf_pkg::MSEL_SQ;
        state_next    = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (stat.mul_done) begin
          cmd.cap_sq = 1'b1;
          state_next = ST_P1_GO;
        end
      end
      ST_P1_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = otf_pkg::MSEL_P1;
        state_next    = ST_P1_WAIT;
      end
      ST_P1_WAIT: begin
        if (stat.mul_done) begin
          cmd.cap_p1 = 1'b1;
          state_next = ST_P2_GO;
        end
      end
      ST_P2_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = otf_pkg::MSEL_P2;
        state_next    = ST_P2_WAIT;
      end
      ST_P2_WAIT: begin
        if (stat.mul_done) begin
          cmd.cap_p2 = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.best_upd = stat.better;
        state_next   = ST_NEXT;
      end
      ST_NEXT: begin
        if (stat.bin_last) begin
          state_next = ST_DONE;
        end else begin
          cmd.bin_inc = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_DONE: begin
        if (!res_valid || !res_stall) begin
          cmd.res_load   = 1'b1;
          cmd.region_clr = 1'b1;
          state_next     = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/otsu_threshold_finder_unit.sv
// top level of the otsu threshold finder: controller, datapath and checks
//
// usage
// - pix channel: one 8-bit gray pixel per beat, pix.last marks the final
//   pixel of a region; pixels arrive at one per cycle while pix_stall is low
// - res channel: one beat per region with the threshold bin and split_found;
//   split_found low means no bin gave positive variance and threshold is 0
// - the 256-bin histogram lives in a ram; intake is a read-modify-write
//   pipeline with a forward register, so equal pixels may come back to back
// - after the last beat the block stalls pix and sweeps all bins one at a
//   time through a shared iterative multiplier (one 8-bit digit a cycle);
//   a bin with an empty class skips the multiplier, any other bin runs the
//   squared difference and both cross products of the compare through it
// - the sweep writes each bin back to zero, so the next region starts clean
// - pixels past the count limit are dropped; their last flag still counts
// - reset: a clearing pass zeroes all 256 histogram bins, pix_stall high
// - a result that waits on res_stall is held in the output register; new
//   pixels are taken meanwhile, and the next result waits for the slot
module otsu_threshold_finder_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           pix_valid,
  output logic           pix_stall,
  input  otf_pkg::pix_t  pix,
  output logic           res_valid,
  input  logic           res_stall,
  output otf_pkg::res_t  res
);

  otf_pkg::cmd_t  cmd;
  otf_pkg::stat_t stat;

  // sequencer: handshakes and the sweep order
  otf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // histogram, totals and exact variance compare
  otf_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .pix  (pix),
    .cmd  (cmd),
    .stat (stat),
    .res  (res)
  );

  // a stalled result beat stays up and unchanged
  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result beat dropped or changed");

  // no split means threshold 0
  a_zero_without_split: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.split_found) |-> (res.threshold == '0))
    else $error("threshold nonzero without split");

  // a new result only appears while intake is held off
  a_result_after_sweep: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pix_stall))
    else $error("result raised while taking pixels");

endmodule

FILE: verif/tb.sv
// self-checking testbench for the otsu threshold finder unit
module tb;

  localparam int MISMATCH_SHOWN = 10;

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_stall;
  otf_pkg::pix_t pix;
  logic res_valid;
  logic res_stall;
  otf_pkg::res_t res;

  // software image of the block: histogram, totals
  int unsigned hist_model[otf_pkg::BIN_COUNT];
  int unsigned count_model;
  longint unsigned gray_sum_model;

  otf_pkg::res_t threshold_q[$];
  int unsigned mismatches = 0;
  int unsigned pixels_sent;
  int unsigned regions_sent;
  int unsigned splits_seen = 0;
  bit no_gaps;

  otsu_threshold_finder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // true when d1^2/den1 > d2^2/den2, exact at 192 bits
  function automatic bit variance_greater(longint unsigned d1, longint unsigned den1,
                                          longint unsigned d2, longint unsigned den2);
    logic [191:0] lhs;
    logic [191:0] rhs;
    lhs = 192'(d1) * 192'(d1) * 192'(den2);
    rhs = 192'(d2) * 192'(d2) * 192'(den1);
    return lhs > rhs;
  endfunction

  // histogram sweep: first bin with strictly largest between-class variance
  function automatic otf_pkg::res_t otsu_sweep();
    otf_pkg::res_t r;
    longint unsigned best_d;
    longint unsigned best_den;
    int unsigned best_t;
    longint unsigned w1;
    longint unsigned s1;
    longint unsigned a;
    longint unsigned b;
    longint unsigned d;
    longint unsigned den;
    best_d = 0;
    best_den = 1;
    best_t = 0;
    w1 = 0;
    s1 = 0;
    for (int t = 0; t < otf_pkg::BIN_COUNT; t++) begin
      w1 += hist_model[t];
      s1 += longint'(hist_model[t]) * t;
      if (w1 == 0 || w1 >= count_model) continue;
      a = count_model * s1;
      b = w1 * gray_sum_model;
      d = (a > b) ? a - b : b - a;
      den = w1 * (count_model - w1);
      if (variance_greater(d, den, best_d, best_den)) begin
        best_d = d;
        best_den = den;
        best_t = t;
      end
    end
    r.split_found = (best_d != 0);
    r.threshold = r.split_found ? otf_pkg::BIN_W'(best_t) : '0;
    return r;
  endfunction

  // accepted beat: update the image, on last push the expected threshold
  function automatic void absorb_pixel(otf_pkg::pix_t p);
    if (count_model < otf_pkg::MAX_REGION_PIXELS) begin
      hist_model[p.pixel]++;
      count_model++;
      gray_sum_model += p.pixel;
    end
    if (p.last) begin
      threshold_q.push_back(otsu_sweep());
      foreach (hist_model[i]) hist_model[i] = 0;
      count_model = 0;
      gray_sum_model = 0;
      regions_sent++;
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one beat on the pixel channel, held until taken
  task automatic send_pixel(logic [otf_pkg::PIX_W-1:0] gray, logic is_last);
    int unsigned gap;
    otf_pkg::pix_t p;
    p.pixel = gray;
    p.last = is_last;
    @(negedge clk);
    pix <= p;
    pix_valid <= 1'b1;
    do @(posedge clk); while (pix_stall);
    absorb_pixel(p);
    pixels_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      pix_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_region(logic [otf_pkg::PIX_W-1:0] grays[$]);
    foreach (grays[i]) send_pixel(grays[i], i == grays.size() - 1);
  endtask

  // receiver stall: random, with calm stretches
  always @(negedge clk) begin
    if (rst || no_gaps) res_stall <= 1'b0;
    else res_stall <= ($urandom_range(0, 99) < 30);
  end

  // compare each delivered threshold beat with the oldest expectation
  always @(posedge clk) begin
    otf_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (threshold_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN)
          $display("unexpected result beat: threshold %0d split %0b",
                   res.threshold, res.split_found);
      end else begin
        want = threshold_q.pop_front();
        if (res.split_found) splits_seen++;
        if (res.threshold !== want.threshold || res.split_found !== want.split_found) begin
          mismatches++;
          if (mismatches <= MISMATCH_SHOWN)
            $display("mismatch: threshold exp %0d got %0d, split exp %0b got %0b",
                     want.threshold, res.threshold, want.split_found, res.split_found);
        end
      end
    end
  end

  // corner regions: single pixel, flat, extremes, ties
  task automatic test_directed();
    logic [otf_pkg::PIX_W-1:0] g[$];
    send_region('{8'd0});
    send_region('{8'd255});
    send_region('{8'd77, 8'd77, 8'd77, 8'd77});
    send_region('{8'd0, 8'd255});
    send_region('{8'd255, 8'd255, 8'd0, 8'd0, 8'd0});
    // equal variance at bins 0 and 1, earliest kept
    send_region('{8'd0, 8'd2});
    send_region('{8'd10, 8'd10, 8'd200, 8'd201, 8'd1});
    // all bits toggled on both fields
    g = '{8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h80, 8'h01};
    send_region(g);
  endtask

  // random regions: mostly short, some long, bimodal, narrow-band or uniform content
  task automatic test_random_regions();
    int unsigned len;
    int unsigned lo_c;
    int unsigned hi_c;
    int unsigned kind;
    logic [otf_pkg::PIX_W-1:0] g[$];
    while (pixels_sent < 1280) begin
      no_gaps = ($urandom_range(0, 9) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 30);
      kind = $urandom_range(0, 3);
      lo_c = $urandom_range(0, 255);
      hi_c = $urandom_range(0, 255);
      g.delete();
      for (int i = 0; i < len; i++) begin
        case (kind)
          0: g.push_back(8'($urandom_range(0, 255)));
          1: g.push_back($urandom_range(0, 1) ? 8'(lo_c) : 8'(hi_c));
          2: g.push_back(8'(lo_c + $urandom_range(0, 3)));
          default: g.push_back($urandom_range(0, 1) ?
                                 8'($urandom_range(0, 40)) : 8'($urandom_range(215, 255)));
        endcase
      end
      send_region(g);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    pixels_sent = 0;
    regions_sent = 0;
    no_gaps = 1'b0;
    foreach (hist_model[i]) hist_model[i] = 0;
    count_model = 0;
    gray_sum_model = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_regions();
    @(negedge clk);
    pix_valid <= 1'b0;

    // drain: wait until every expected result has been checked
    while (threshold_q.size() != 0) @(posedge clk);
    repeat (9000) @(posedge clk);
    $display("covered %0d pixels in %0d regions, %0d with a split, under random gaps and stalls",
             pixels_sent, regions_sent, splits_seen);
    if (mismatches == 0 && threshold_q.size() == 0) begin
      $display("otsu_threshold_finder_unit regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, threshold_q.size());
      $display("otsu_threshold_finder_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("timeout with %0d results outstanding", threshold_q.size());
    $display("otsu_threshold_finder_unit regression: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/otf_pkg.sv
rtl/otf_ram.sv
rtl/otf_mul.sv
rtl/otf_datapath.sv
rtl/otf_ctrl.sv
rtl/otsu_threshold_finder_unit.sv
verif/tb.sv
